FILE: hdl/dfiir_pkg.sv
// Shared types, constants and microprogram for the direct-form-I IIR biquad.
// Used by direct_form_iir_filter_unit; no other dependencies.
package dfiir_pkg;

  localparam int TAP_COUNT  = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 3;   // five products, signed
  localparam int MAG_W      = ACC_W - 2;    // |acc| < 2^33
  localparam int NUM_W      = MAG_W + 1;    // |acc| + |a0|/2
  localparam int QUO_W      = 17;           // quotient bits resolved by the loop
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 5;
  localparam int PC_W       = 3;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;

  localparam logic signed [COEF_W-1:0] UNITY = 16'sd4096;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MAC_ADD,
    OP_MAC_SUB,
    OP_PREP,
    OP_DIV,
    OP_FIN
  } op_t;

  // which coefficient / history pair feeds the multiplier
  typedef enum logic [2:0] {
    TAP_B0_X0,
    TAP_B1_X1,
    TAP_B2_X2,
    TAP_A1_Y1,
    TAP_A2_Y2
  } tap_t;

  typedef enum logic [1:0] {
    JMP_NONE,     // fall through
    JMP_SPECIAL,  // zero divisor or quotient overflow
    JMP_DIV_LOOP  // more quotient bits to go
  } jmp_t;

  typedef struct packed {
    op_t             op;
    tap_t            tap;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_FIRST = 3'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 3'd6;
  localparam logic [PC_W-1:0] PC_FIN   = 3'd7;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, tap: TAP_B0_X0, jmp: JMP_NONE, target: PC_FIRST};
    case (pc)
      3'd0: w = '{op: OP_MAC_ADD, tap: TAP_B0_X0, jmp: JMP_NONE, target: PC_FIRST};
      3'd1: w = '{op: OP_MAC_ADD, tap: TAP_B1_X1, jmp: JMP_NONE, target: PC_FIRST};
      3'd2: w = '{op: (TAP_COUNT > 2) ? OP_MAC_ADD : OP_NOP, tap: TAP_B2_X2,
                  jmp: JMP_NONE, target: PC_FIRST};
      3'd3: w = '{op: OP_MAC_SUB, tap: TAP_A1_Y1, jmp: JMP_NONE, target: PC_FIRST};
      3'd4: w = '{op: (TAP_COUNT > 2) ? OP_MAC_SUB : OP_NOP, tap: TAP_A2_Y2,
                  jmp: JMP_NONE, target: PC_FIRST};
      3'd5: w = '{op: OP_PREP, tap: TAP_B0_X0, jmp: JMP_SPECIAL, target: PC_FIN};
      3'd6: w = '{op: OP_DIV, tap: TAP_B0_X0, jmp: JMP_DIV_LOOP, target: PC_DIV};
      3'd7: w = '{op: OP_FIN, tap: TAP_B0_X0, jmp: JMP_NONE, target: PC_FIRST};
      default: w = '{op: OP_NOP, tap: TAP_B0_X0, jmp: JMP_NONE, target: PC_FIRST};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/direct_form_iir_filter_unit.sv
// Direct-form-I IIR biquad, Q1.15 samples, Q4.12 coefficients, microcoded datapath.
// Depends on dfiir_pkg (types, constants, microprogram ROM).
//
// Usage:
//   in_*  : one sample per word, in_tdata = sample_in, in_tlast = last_sample.
//   out_* : one result per input word, out_tdata = sample_out, out_tlast = last_out,
//           out_tuser = saturated (clipped, or coef_a0 was zero).
//   cfg_* : write coefficient cfg_index (b0,b1,b2,a0,a1,a2 = 0..5) while idle.
//   After acceptance a sample passes through five multiply-accumulate steps,
//   one setup step, 17 restoring-divider steps by |a0| and one finish step.
//   With a zero a0 or a quotient overflow the divider is skipped.
//   in_tready is high only while no sample is in flight, so a new sample is
//   taken the cycle after the previous one is written to the output register.
//   A stalled receiver holds the result in the output register; the next
//   sample is still accepted and computed, and waits at its finish step
//   until the output register frees up.
//   Histories are cleared after a sample marked last.
//   Reset (rst_n low, synchronous) restores b0 = a0 = 1.0, other coefficients
//   zero, clears histories and drops out_tvalid.
module direct_form_iir_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] saturated
  input  logic        cfg_wr_en,
  input  logic [dfiir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dfiir_pkg::*;

  // coefficients
  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a0_r, a1_r, a2_r;
  // histories and current sample
  logic signed [SAMPLE_W-1:0] x0_r, x1_r, x2_r, y1_r, y2_r;
  logic                       last_r;

  logic                   busy_r, busy_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [15:0]            dv_r, dv_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic [QUO_W-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   zero_r, zero_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_sat_r, out_sat_nxt;

  ctrl_t                      cw;
  logic                       in_take, fin_go, hist_upd;
  logic signed [COEF_W-1:0]   mul_c;
  logic signed [SAMPLE_W-1:0] mul_d;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_abs;
  logic signed [COEF_W:0]     a0_ext, a0_abs;
  logic [15:0]                d_mag;
  logic [NUM_W-1:0]           numer;
  logic                       a0_zero, pre_ovf;
  logic [QUO_W-1:0]           trial;
  logic                       trial_ge;
  logic signed [SAMPLE_W-1:0] y_val;
  logic                       y_sat;

  assign cw        = ucode(pc_r);
  assign in_tready = !busy_r;
  assign in_take   = in_tvalid && !busy_r;
  assign fin_go    = busy_r && (cw.op == OP_FIN) && (!out_valid_r || out_tready);
  assign hist_upd  = fin_go;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_sat_r;

  // multiplier operand selection
  always_comb begin
    case (cw.tap)
      TAP_B0_X0: begin mul_c = b0_r; mul_d = x0_r; end
      TAP_B1_X1: begin mul_c = b1_r; mul_d = x1_r; end
      TAP_B2_X2: begin mul_c = b2_r; mul_d = x2_r; end
      TAP_A1_Y1: begin mul_c = a1_r; mul_d = y1_r; end
      TAP_A2_Y2: begin mul_c = a2_r; mul_d = y2_r; end
      default:   begin mul_c = b0_r; mul_d = x0_r; end
    endcase
  end

  assign prod     = mul_c * mul_d;
  assign prod_ext = ACC_W'(prod);

  // setup for the divider: magnitudes and rounding offset
  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign a0_ext  = (COEF_W+1)'(a0_r);
  assign a0_abs  = a0_r[COEF_W-1] ? -a0_ext : a0_ext;
  assign d_mag   = a0_abs[15:0];
  assign numer   = {1'b0, acc_abs[MAG_W-1:0]} + NUM_W'(d_mag >> 1);
  assign a0_zero = (a0_r == '0);
  // quotient would need more than QUO_W bits: saturates for sure
  assign pre_ovf = (numer[NUM_W-1:NUM_W-QUO_W] >= {1'b0, d_mag});

  // one restoring step
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, dv_r});

  // final rounding sign and clamp
  always_comb begin
    y_val = '0;
    y_sat = 1'b0;
    if (zero_r) begin
      y_val = '0;
      y_sat = 1'b1;
    end else if (ovf_r) begin
      y_sat = 1'b1;
      y_val = neg_r ? 16'sh8000 : 16'sh7fff;
    end else if (neg_r && quo_r != '0) begin
      if (quo_r > 17'd32768) begin
        y_val = 16'sh8000;
        y_sat = 1'b1;
      end else begin
        y_val = SAMPLE_W'(-$signed({1'b0, quo_r}));
      end
    end else begin
      if (quo_r > 17'd32767) begin
        y_val = 16'sh7fff;
        y_sat = 1'b1;
      end else begin
        y_val = quo_r[15:0];
      end
    end
  end

  // sequencer and datapath next state
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    acc_nxt       = acc_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_sat_nxt   = out_sat_r;

    if (in_take) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_FIRST;
      acc_nxt  = '0;
    end else if (busy_r) begin
      pc_nxt = pc_r + PC_W'(1);
      case (cw.op)
        OP_MAC_ADD: acc_nxt = acc_r + prod_ext;
        OP_MAC_SUB: acc_nxt = acc_r - prod_ext;
        OP_PREP: begin
          dv_nxt   = d_mag;
          // high part is below |a0| here, so it fits the remainder register
          rem_nxt  = numer[NUM_W-2:QUO_W];
          quo_nxt  = numer[QUO_W-1:0];
          cnt_nxt  = '0;
          neg_nxt  = acc_r[ACC_W-1] ^ a0_r[COEF_W-1];
          zero_nxt = a0_zero;
          ovf_nxt  = pre_ovf;
          if ((cw.jmp == JMP_SPECIAL) && (a0_zero || pre_ovf)) pc_nxt = cw.target;
        end
        OP_DIV: begin
          rem_nxt = trial_ge ? 16'(trial - {1'b0, dv_r}) : trial[15:0];
          quo_nxt = {quo_r[QUO_W-2:0], trial_ge};
          cnt_nxt = cnt_r + CNT_W'(1);
          if ((cw.jmp == JMP_DIV_LOOP) && (cnt_r != CNT_W'(DIV_STEPS - 1)))
            pc_nxt = cw.target;
        end
        OP_FIN: begin
          if (fin_go) begin
            busy_nxt      = 1'b0;
            pc_nxt        = PC_FIRST;
            out_valid_nxt = 1'b1;
            out_data_nxt  = y_val;
            out_last_nxt  = last_r;
            out_sat_nxt   = y_sat;
          end else begin
            pc_nxt = pc_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_FIRST;
      out_valid_r <= 1'b0;
      b0_r <= UNITY;
      b1_r <= '0;
      b2_r <= '0;
      a0_r <= UNITY;
      a1_r <= '0;
      a2_r <= '0;
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_B0:  b0_r <= cfg_wdata;
          REG_B1:  b1_r <= cfg_wdata;
          REG_B2:  b2_r <= cfg_wdata;
          REG_A0:  a0_r <= cfg_wdata;
          REG_A1:  a1_r <= cfg_wdata;
          REG_A2:  a2_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (hist_upd) begin
        if (last_r) begin
          x1_r <= '0;
          x2_r <= '0;
          y1_r <= '0;
          y2_r <= '0;
        end else begin
          x1_r <= x0_r;
          x2_r <= x1_r;
          y1_r <= y_val;
          y2_r <= y1_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      x0_r   <= in_tdata;
      last_r <= in_tlast;
    end
    acc_r      <= acc_nxt;
    dv_r       <= dv_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_sat_r  <= out_sat_nxt;
  end

endmodule
